// ===== rtl/wavrp_pkg.sv =====
// Shared constants for the RIFF/WAVE header parser: chunk tags, format tags,
// status codes and the width of the byte position counter.
// No dependencies.
`default_nettype none

package wavrp_pkg;

    // Byte position counter width (16 to 32); the data offset port stays 32 bits.
    localparam int POSITION_BITS = 32;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM = 16'h0001;
    localparam logic [15:0] FMT_EXT = 16'hFFFE;

    localparam logic [31:0] FMT_MIN_LEN     = 32'd16;
    localparam logic [31:0] FMT_BAD_LEN     = 32'd17;
    localparam logic [31:0] EXT_MIN_LEN     = 32'd40;
    localparam logic [15:0] EXT_MIN_EXTSIZE = 16'd22;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_NOSUP = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/wav_riff_header_parser_unit.sv =====
// RIFF/WAVE header parser top level: byte-wise chunk walker and result register.
// Depends on wavrp_pkg.
`default_nettype none

// The block takes a WAV file one byte per request and, on the request marked
// as the last byte, returns one result with the status (ok, invalid or
// unsupported) and, when ok, the format of the last valid fmt chunk and the
// place of the last data chunk. A byte can be taken in every cycle unless the
// input stalls: each byte is held in an input register, then a single pass of
// compares and counter updates advances the parse state and, on the last
// byte, loads the result register. The input stalls only while a finished
// result waits and a new last byte is ready behind it. After the last byte
// the parser starts over on a new file.
module wav_riff_header_parser_unit
    import wavrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_file_byte,
    input  wire logic        i_end_of_file,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_channel_count,
    output logic [31:0]      o_sample_rate,
    output logic [5:0]       o_sample_bits,
    output logic [15:0]      o_frame_bytes,
    output logic [1:0]       o_sample_format,
    output logic [31:0]      o_data_offset,
    output logic [31:0]      o_data_length
);

    typedef enum logic [1:0] {PH_RIFF, PH_HEADER, PH_PAYLOAD, PH_PAD} t_phase;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eof;

    // Parse state
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [31:0] r_left, n_left;
    logic        r_pad, n_pad;
    logic [15:0] r_ftag, n_ftag;
    logic [15:0] r_ext, n_ext;
    logic [15:0] r_cur_ch, n_cur_ch;
    logic [31:0] r_cur_rate, n_cur_rate;
    logic [15:0] r_cur_align, n_cur_align;
    logic [15:0] r_cur_bits, n_cur_bits;
    logic [15:0] r_last_ch, n_last_ch;
    logic [31:0] r_last_rate, n_last_rate;
    logic [15:0] r_last_align, n_last_align;
    logic [15:0] r_last_bits, n_last_bits;
    logic [31:0] r_data_off, n_data_off;
    logic [31:0] r_data_len, n_data_len;
    logic [1:0]  r_seen, n_seen;
    logic [1:0]  r_err, n_err;

    // Result register
    logic        r_out_valid;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_ch, r_align;
    logic [31:0] r_rate, r_off, r_dlen;
    logic [5:0]  r_bits;
    logic [1:0]  r_fmt;

    logic                     w_advance;
    logic                     w_finish;
    logic [31:0]              w_fidx;
    logic [POSITION_BITS-1:0] w_pos_inc;

    // A byte without end of file never needs the result register.
    assign w_advance = r_in_valid && (!r_in_eof || !r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;

    assign w_pos_inc = r_pos + POSITION_BITS'(1);
    assign w_fidx    = r_len - r_left;

    always_comb begin
        n_pos        = w_pos_inc;
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_tag        = r_tag;
        n_len        = r_len;
        n_left       = r_left;
        n_pad        = r_pad;
        n_ftag       = r_ftag;
        n_ext        = r_ext;
        n_cur_ch     = r_cur_ch;
        n_cur_rate   = r_cur_rate;
        n_cur_align  = r_cur_align;
        n_cur_bits   = r_cur_bits;
        n_last_ch    = r_last_ch;
        n_last_rate  = r_last_rate;
        n_last_align = r_last_align;
        n_last_bits  = r_last_bits;
        n_data_off   = r_data_off;
        n_data_len   = r_data_len;
        n_seen       = r_seen;
        n_err        = r_err;
        w_finish     = 1'b0;

        if (r_err == ST_OK) begin
            unique case (r_phase)
                PH_RIFF: begin
                    n_tag = {r_tag[23:0], r_in_byte};
                    if (r_idx == 4'd3 && n_tag != TAG_RIFF) begin
                        n_err = ST_INVAL;
                    end
                    if (r_idx == 4'd11) begin
                        if (n_tag != TAG_WAVE) begin
                            n_err = ST_INVAL;
                        end
                        n_phase = PH_HEADER;
                        n_idx   = 4'd0;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_HEADER: begin
                    if (r_idx < 4'd4) begin
                        n_tag = (r_idx == 4'd0) ? {24'd0, r_in_byte}
                                                : {r_tag[23:0], r_in_byte};
                    end else begin
                        unique case (r_idx[1:0])
                            2'd0: n_len[7:0]   = r_len[7:0]   | r_in_byte;
                            2'd1: n_len[15:8]  = r_len[15:8]  | r_in_byte;
                            2'd2: n_len[23:16] = r_len[23:16] | r_in_byte;
                            2'd3: n_len[31:24] = r_len[31:24] | r_in_byte;
                        endcase
                    end
                    if (r_idx >= 4'd7) begin
                        n_left      = n_len;
                        n_pad       = n_len[0];
                        n_ftag      = '0;
                        n_ext       = '0;
                        n_cur_ch    = '0;
                        n_cur_rate  = '0;
                        n_cur_align = '0;
                        n_cur_bits  = '0;
                        if (n_tag == TAG_DATA) begin
                            n_data_off = 32'(w_pos_inc);
                            n_data_len = n_len;
                            n_seen[1]  = 1'b1;
                        end
                        n_idx = 4'd0;
                        if (n_len == 32'd0) begin
                            w_finish = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        if (r_idx == 4'd3) begin
                            n_len = '0;
                        end
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_tag == TAG_FMT) begin
                        unique case (w_fidx)
                            32'd0:   n_ftag[7:0]         = r_in_byte;
                            32'd1:   n_ftag[15:8]        = r_in_byte;
                            32'd2:   n_cur_ch[7:0]       = r_in_byte;
                            32'd3:   n_cur_ch[15:8]      = r_in_byte;
                            32'd4:   n_cur_rate[7:0]     = r_in_byte;
                            32'd5:   n_cur_rate[15:8]    = r_in_byte;
                            32'd6:   n_cur_rate[23:16]   = r_in_byte;
                            32'd7:   n_cur_rate[31:24]   = r_in_byte;
                            32'd12:  n_cur_align[7:0]    = r_in_byte;
                            32'd13:  n_cur_align[15:8]   = r_in_byte;
                            32'd14:  n_cur_bits[7:0]     = r_in_byte;
                            32'd15:  n_cur_bits[15:8]    = r_in_byte;
                            32'd16:  n_ext[7:0]          = r_in_byte;
                            32'd17:  n_ext[15:8]         = r_in_byte;
                            default: ;
                        endcase
                    end
                    n_left = r_left - 32'd1;
                    if (n_left == 32'd0) begin
                        w_finish = 1'b1;
                    end
                end
                PH_PAD: begin
                    n_phase = PH_HEADER;
                    n_idx   = 4'd0;
                end
            endcase

            // End of a chunk payload: judge a fmt chunk, then go to the pad byte, if any, or the next header.
            if (w_finish) begin
                if (n_tag == TAG_FMT) begin
                    priority if (n_len < FMT_MIN_LEN || n_len == FMT_BAD_LEN) begin
                        n_err = ST_INVAL;
                    end else if (n_len > FMT_MIN_LEN && n_ftag == FMT_EXT
                                 && (n_ext < EXT_MIN_EXTSIZE || n_len < EXT_MIN_LEN)) begin
                        n_err = ST_INVAL;
                    end else if (n_ftag != FMT_PCM && n_ftag != FMT_EXT) begin
                        n_err = ST_NOSUP;
                    end else if (n_cur_bits != 16'd8 && n_cur_bits != 16'd16
                                 && n_cur_bits != 16'd24 && n_cur_bits != 16'd32) begin
                        n_err = ST_NOSUP;
                    end else begin
                        n_last_ch    = n_cur_ch;
                        n_last_rate  = n_cur_rate;
                        n_last_align = n_cur_align;
                        n_last_bits  = n_cur_bits;
                        n_seen[0]    = 1'b1;
                    end
                end
                n_phase = n_pad ? PH_PAD : PH_HEADER;
                n_idx   = 4'd0;
            end
        end

        priority if (n_err != ST_OK) begin
            n_status = n_err;
        end else if (n_phase == PH_RIFF || n_phase == PH_PAYLOAD) begin
            n_status = ST_INVAL;
        end else if (n_seen != 2'b11) begin
            n_status = ST_INVAL;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_in_byte <= i_file_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_advance && r_in_eof)) begin
            r_pos        <= '0;
            r_phase      <= PH_RIFF;
            r_idx        <= '0;
            r_tag        <= '0;
            r_len        <= '0;
            r_left       <= '0;
            r_pad        <= 1'b0;
            r_ftag       <= '0;
            r_ext        <= '0;
            r_cur_ch     <= '0;
            r_cur_rate   <= '0;
            r_cur_align  <= '0;
            r_cur_bits   <= '0;
            r_last_ch    <= '0;
            r_last_rate  <= '0;
            r_last_align <= '0;
            r_last_bits  <= '0;
            r_data_off   <= '0;
            r_data_len   <= '0;
            r_seen       <= '0;
            r_err        <= ST_OK;
        end else if (w_advance) begin
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_tag        <= n_tag;
            r_len        <= n_len;
            r_left       <= n_left;
            r_pad        <= n_pad;
            r_ftag       <= n_ftag;
            r_ext        <= n_ext;
            r_cur_ch     <= n_cur_ch;
            r_cur_rate   <= n_cur_rate;
            r_cur_align  <= n_cur_align;
            r_cur_bits   <= n_cur_bits;
            r_last_ch    <= n_last_ch;
            r_last_rate  <= n_last_rate;
            r_last_align <= n_last_align;
            r_last_bits  <= n_last_bits;
            r_data_off   <= n_data_off;
            r_data_len   <= n_data_len;
            r_seen       <= n_seen;
            r_err        <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_eof) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && r_in_eof) begin
            r_status <= n_status;
            if (n_status == ST_OK) begin
                r_ch    <= n_last_ch;
                r_rate  <= n_last_rate;
                r_bits  <= n_last_bits[5:0];
                r_align <= n_last_align;
                r_fmt   <= n_last_bits[4:3] - 2'd1;
                r_off   <= n_data_off;
                r_dlen  <= n_data_len;
            end else begin
                r_ch    <= '0;
                r_rate  <= '0;
                r_bits  <= '0;
                r_align <= '0;
                r_fmt   <= '0;
                r_off   <= '0;
                r_dlen  <= '0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_channel_count = r_ch;
    assign o_sample_rate   = r_rate;
    assign o_sample_bits   = r_bits;
    assign o_frame_bytes   = r_align;
    assign o_sample_format = r_fmt;
    assign o_data_offset   = r_off;
    assign o_data_length   = r_dlen;

endmodule

`default_nettype wire
